// File: src/imu_quaternion_attitude_update_unit_macros.svh
// Assertion helpers used by the top-level RTL
`ifndef IMU_QUATERNION_ATTITUDE_UPDATE_UNIT_MACROS_SVH
`define IMU_QUATERNION_ATTITUDE_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/imu_att_pkg.sv
package imu_att_pkg;

  localparam int QUAT_WIDTH = 32;
  localparam int QUANT_SHIFT = (QUAT_WIDTH < 32) ? 32 - QUAT_WIDTH : 0;
  localparam int QUANT_SHIFT_M1 = (QUANT_SHIFT > 0) ? QUANT_SHIFT - 1 : 0;
  localparam int GW = 34;
  localparam int OPW = 35;
  localparam int ACCW = 66;
  localparam logic [15:0] GAIN_RESET = 16'd2560;
  localparam logic [26:0] DEG_TO_RAD = 27'd74961321;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_MAC, DP_ANORM, DP_ASQRT, DP_ADIV, DP_QMAG,
    DP_QRSH, DP_QLSH, DP_QSQRT, DP_QDIV, DP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    SRC_GYRO, SRC_ACC, SRC_Q, SRC_AN, SRC_M, SRC_V, SRC_G, SRC_E, SRC_DD,
    SRC_GAIN, SRC_DEG, SRC_DT
  } src_t;

  typedef enum logic [1:0] {ACC_LOAD, ACC_LOADN, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_G, DST_S, DST_V, DST_E, DST_GADD, DST_DD, DST_NQ, DST_SUM
  } dst_t;

  typedef struct packed {
    dp_op_t      op;
    src_t        a_src;
    logic [1:0]  a_idx;
    src_t        b_src;
    logic [1:0]  b_idx;
    acc_op_t     acc_op;
    dst_t        dst;
    logic [1:0]  dst_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic s_norm;
    logic m_zero;
    logic m_big;
    logic m_small;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic dp_cmd_t mac(input src_t a, input logic [1:0] ai, input src_t b,
                                  input logic [1:0] bi, input acc_op_t o, input dst_t d,
                                  input logic [1:0] di);
    dp_cmd_t c;
    c.op = DP_MAC;
    c.a_src = a;
    c.a_idx = ai;
    c.b_src = b;
    c.b_idx = bi;
    c.acc_op = o;
    c.dst = d;
    c.dst_idx = di;
    return c;
  endfunction

  // Round half away from zero on a right shift
  function automatic logic signed [ACCW-1:0] rshr(input logic signed [ACCW-1:0] v,
                                                   input int unsigned sh);
    logic [ACCW-1:0] m;
    logic [ACCW-1:0] r;
    m = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    r = (m + (ACCW'(1) << (sh - 1))) >> sh;
    return v[ACCW-1] ? -$signed(r) : $signed(r);
  endfunction

  // Round a stored component to the attitude grid
  function automatic logic signed [31:0] quantize(input logic [32:0] mag, input logic neg);
    logic [32:0] m;
    m = mag;
    if (QUANT_SHIFT > 0) begin
      m = ((m + (33'(1) << QUANT_SHIFT_M1)) >> QUANT_SHIFT) << QUANT_SHIFT;
    end
    return neg ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

endpackage

// File: src/imu_quaternion_attitude_update_unit.sv
// Each update is mostly spent in the shared bit-serial square root and divider, used twice
// and seven times, plus the accel and quaternion normalization shifts.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// A zero accel vector skips the correction.
// Reset (rst, synchronous): attitude to identity, gain to 10.0, output empty.
`include "imu_quaternion_attitude_update_unit_macros.svh"

module imu_quaternion_attitude_update_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, step_time (from bit 0)
  input  logic [215:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z (from bit 0)
  output logic [127:0] m_axis_tdata,
  // accel_invalid
  output logic         m_axis_tuser,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  imu_att_pkg::dp_cmd_t  cmd;
  imu_att_pkg::dp_stat_t stat;

  imu_att_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  imu_att_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_data    (m_axis_tdata),
    .out_flag    (m_axis_tuser)
  );

  // One request in flight at a time
  `ASSERT_NEXT(a_one_request, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A new result only comes out of a busy update
  `ASSERT_IMP(a_result_after_work, clk, rst, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

// File: src/imu_att_sqrt.sv
module imu_att_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bit_pos;
  logic [64:0] trial;

  assign trial = {1'b0, res} + {1'b0, bit_pos};
  assign root = res[31:0];

  // One result bit per step, the bit position moving two places, one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= value;
        res <= '0;
        bit_pos <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[63:0];
          res <= (res >> 1) + bit_pos;
        end else begin
          res <= res >> 1;
        end
        bit_pos <= bit_pos >> 2;
        if (bit_pos[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/imu_att_div.sv
module imu_att_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [32:0] quot
);

  logic        busy;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [32:0] feed;
  logic [32:0] trial;

  assign trial = {rem, feed[32]};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd33;
        rem <= {1'b0, num[63:33]};
        feed <= num[32:0];
        quot <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= 32'(trial - {1'b0, den});
          quot <= {quot[31:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quot <= {quot[31:0], 1'b0};
        end
        feed <= {feed[31:0], 1'b0};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/imu_att_datapath.sv
module imu_att_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  imu_att_pkg::dp_cmd_t  cmd,
  output imu_att_pkg::dp_stat_t stat,
  input  logic [215:0]          in_data,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [127:0]          out_data,
  output logic                  out_flag
);

  localparam int GW = imu_att_pkg::GW;
  localparam int OPW = imu_att_pkg::OPW;
  localparam int ACCW = imu_att_pkg::ACCW;

  logic signed [31:0]     gyro [4];
  logic signed [31:0]     ain [4];
  logic [63:0]            am [4];
  logic [23:0]            dt;
  logic [63:0]            s;
  logic [63:0]            sum;
  logic signed [GW-1:0]   g [4];
  logic signed [GW-1:0]   v [4];
  logic signed [GW-1:0]   e [4];
  logic signed [GW-1:0]   an [4];
  logic signed [GW-1:0]   dd [4];
  logic signed [63:0]     nq [4];
  logic [63:0]            m [4];
  logic signed [31:0]     q [4];
  logic [15:0]            gain;

  logic signed [2*OPW-1:0] prod;
  logic                    c1_mac;
  imu_att_pkg::acc_op_t    c1_op;
  imu_att_pkg::dst_t       c1_dst;
  imu_att_pkg::dst_t       c2_dst;
  logic [1:0]              c1_idx;
  logic [1:0]              c2_idx;
  logic signed [ACCW-1:0]  acc;
  logic signed [ACCW-1:0]  prod_w;
  logic signed [OPW-1:0]   opa;
  logic signed [OPW-1:0]   opb;

  logic        sq_start;
  logic [63:0] sq_value;
  logic        sq_done;
  logic [31:0] sq_root;
  logic        dv_start;
  logic [63:0] dv_num;
  logic        dv_done;
  logic [32:0] dv_quot;
  logic        dv_kind;
  logic [1:0]  dv_idx;

  function automatic logic signed [OPW-1:0] operand(input imu_att_pkg::src_t src,
                                                    input logic [1:0] i);
    logic signed [OPW-1:0] r;
    unique case (src)
      imu_att_pkg::SRC_GYRO: r = OPW'(gyro[i]);
      imu_att_pkg::SRC_ACC:  r = OPW'(ain[i]);
      imu_att_pkg::SRC_Q:    r = OPW'(q[i]);
      imu_att_pkg::SRC_AN:   r = OPW'(an[i]);
      imu_att_pkg::SRC_M:    r = $signed({1'b0, m[i][OPW-2:0]});
      imu_att_pkg::SRC_V:    r = OPW'(v[i]);
      imu_att_pkg::SRC_G:    r = OPW'(g[i]);
      imu_att_pkg::SRC_E:    r = OPW'(e[i]);
      imu_att_pkg::SRC_DD:   r = OPW'(dd[i]);
      imu_att_pkg::SRC_GAIN: r = $signed(OPW'(gain));
      imu_att_pkg::SRC_DEG:  r = $signed(OPW'(imu_att_pkg::DEG_TO_RAD));
      imu_att_pkg::SRC_DT:   r = $signed(OPW'(dt));
      default:               r = '0;
    endcase
    return r;
  endfunction

  assign opa = operand(cmd.a_src, cmd.a_idx);
  assign opb = operand(cmd.b_src, cmd.b_idx);
  assign prod_w = ACCW'(prod);

  // Start shared sqrt and divider units
  assign sq_start = (cmd.op == imu_att_pkg::DP_ASQRT) || (cmd.op == imu_att_pkg::DP_QSQRT);
  assign sq_value = (cmd.op == imu_att_pkg::DP_ASQRT) ? s : sum;
  assign dv_start = (cmd.op == imu_att_pkg::DP_ADIV) || (cmd.op == imu_att_pkg::DP_QDIV);
  assign dv_num = ((cmd.op == imu_att_pkg::DP_ADIV) ? (am[cmd.a_idx] << 30)
                                                    : (m[cmd.a_idx] << 30))
                  + {33'd0, sq_root[31:1]};

  imu_att_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  imu_att_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (sq_root),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  // Status back to the controller
  always_comb begin
    stat.s_zero = (s == 64'd0);
    stat.s_norm = (s[63:62] != 2'b00);
    stat.m_zero = 1'b1;
    stat.m_big = 1'b0;
    stat.m_small = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (m[i] != 64'd0) stat.m_zero = 1'b0;
      if (m[i][63:31] != '0) stat.m_big = 1'b1;
      if (m[i][63:30] != '0) stat.m_small = 1'b0;
    end
    stat.sqrt_done = sq_done;
    stat.div_done = dv_done;
    stat.out_free = !out_valid || out_ready;
  end

  // Control state: attitude, gain, output valid, MAC pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      q[0] <= imu_att_pkg::ONE_Q30;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= '0;
      gain <= imu_att_pkg::GAIN_RESET;
      out_valid <= 1'b0;
      c1_mac <= 1'b0;
      c2_dst <= imu_att_pkg::DST_NONE;
    end else begin
      if (cfg_wr_en) gain <= cfg_wr_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.op == imu_att_pkg::DP_OUT) out_valid <= 1'b1;
      c1_mac <= (cmd.op == imu_att_pkg::DP_MAC);
      c2_dst <= c1_mac ? c1_dst : imu_att_pkg::DST_NONE;
      if (dv_done && !dv_kind) begin
        q[dv_idx] <= imu_att_pkg::quantize(dv_quot, nq[dv_idx][63]);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Multiply stage
    prod <= opa * opb;
    c1_op <= cmd.acc_op;
    c1_dst <= cmd.dst;
    c1_idx <= cmd.dst_idx;
    c2_idx <= c1_idx;

    // Accumulate stage
    if (c1_mac) begin
      unique case (c1_op)
        imu_att_pkg::ACC_LOAD:  acc <= prod_w;
        imu_att_pkg::ACC_LOADN: acc <= -prod_w;
        imu_att_pkg::ACC_ADD:   acc <= acc + prod_w;
        imu_att_pkg::ACC_SUB:   acc <= acc - prod_w;
        default:                acc <= acc;
      endcase
    end

    // Store stage
    unique case (c2_dst)
      imu_att_pkg::DST_G:    g[c2_idx] <= GW'(imu_att_pkg::rshr(acc, 32));
      imu_att_pkg::DST_S:    s <= acc[63:0];
      imu_att_pkg::DST_V:    v[c2_idx] <= GW'(imu_att_pkg::rshr(acc,
                                                 (c2_idx == 2'd2) ? 30 : 29));
      imu_att_pkg::DST_E:    e[c2_idx] <= GW'(imu_att_pkg::rshr(acc, 30));
      imu_att_pkg::DST_GADD: g[c2_idx] <= g[c2_idx] + GW'(imu_att_pkg::rshr(acc, 22));
      imu_att_pkg::DST_DD:   dd[c2_idx] <= GW'(imu_att_pkg::rshr(acc, 26));
      imu_att_pkg::DST_NQ:   nq[c2_idx] <= 64'(q[c2_idx])
                                           + 64'(imu_att_pkg::rshr(acc, 15));
      imu_att_pkg::DST_SUM:  sum <= acc[63:0];
      default: ;
    endcase

    // Item load, normalization steps and output capture
    unique case (cmd.op)
      imu_att_pkg::DP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          gyro[i] <= in_data[32*i +: 32];
          ain[i] <= in_data[96 + 32*i +: 32];
          am[i] <= in_data[96 + 32*i + 31] ? 64'(-$signed(in_data[96 + 32*i +: 32]))
                                           : 64'(in_data[96 + 32*i +: 32]);
          e[i] <= '0;
        end
        gyro[3] <= '0;
        ain[3] <= '0;
        am[3] <= '0;
        e[3] <= '0;
        dt <= in_data[215:192];
      end
      imu_att_pkg::DP_ANORM: begin
        s <= s << 2;
        for (int i = 0; i < 4; i++) am[i] <= am[i] << 1;
      end
      imu_att_pkg::DP_QMAG: begin
        for (int i = 0; i < 4; i++) m[i] <= nq[i][63] ? 64'(-nq[i]) : 64'(nq[i]);
      end
      imu_att_pkg::DP_QRSH: begin
        for (int i = 0; i < 4; i++) m[i] <= m[i] >> 1;
      end
      imu_att_pkg::DP_QLSH: begin
        for (int i = 0; i < 4; i++) m[i] <= m[i] << 1;
      end
      imu_att_pkg::DP_OUT: begin
        out_data <= {q[3], q[2], q[1], q[0]};
        out_flag <= (s == 64'd0);
      end
      default: ;
    endcase

    // Track which quotient is in flight and store accel quotients
    if (dv_start) begin
      dv_kind <= (cmd.op == imu_att_pkg::DP_ADIV);
      dv_idx <= cmd.a_idx;
    end
    if (dv_done && dv_kind) begin
      an[dv_idx] <= ain[dv_idx][31] ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
    end
  end

endmodule

// File: src/imu_att_ctrl.sv
module imu_att_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imu_att_pkg::dp_stat_t stat,
  output imu_att_pkg::dp_cmd_t  cmd
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_PRE   = 15'b000000000000010,
    ST_ANORM = 15'b000000000000100,
    ST_ASQRT = 15'b000000000001000,
    ST_ADIV  = 15'b000000000010000,
    ST_ERR   = 15'b000000000100000,
    ST_GAIN  = 15'b000000001000000,
    ST_DERIV = 15'b000000010000000,
    ST_STEP  = 15'b000000100000000,
    ST_QMAG  = 15'b000001000000000,
    ST_QNORM = 15'b000010000000000,
    ST_QSUM  = 15'b000100000000000,
    ST_QSQRT = 15'b001000000000000,
    ST_QDIV  = 15'b010000000000000,
    ST_OUT   = 15'b100000000000000
  } state_t;

  localparam logic [3:0] PRE_LEN = 4'd14;
  localparam logic [3:0] ERR_LEN = 4'd6;
  localparam logic [3:0] GAIN_LEN = 4'd3;
  localparam logic [3:0] DERIV_LEN = 4'd12;
  localparam logic [3:0] STEP_LEN = 4'd4;
  localparam logic [3:0] QSUM_LEN = 4'd4;

  state_t state;
  state_t state_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic pend;
  logic pend_next;
  logic [3:0] len;
  imu_att_pkg::dp_cmd_t prog;

  // Multiply-accumulate programs, one product a cycle
  always_comb begin
    prog = '0;
    len = 4'd0;
    unique case (state)
      ST_PRE: begin
        len = PRE_LEN;
        unique case (cnt)
          4'd0: prog = imu_att_pkg::mac(imu_att_pkg::SRC_GYRO, 2'd0, imu_att_pkg::SRC_DEG,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_G, 2'd0);
          4'd1: prog = imu_att_pkg::mac(imu_att_pkg::SRC_GYRO, 2'd1, imu_att_pkg::SRC_DEG,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_G, 2'd1);
          4'd2: prog = imu_att_pkg::mac(imu_att_pkg::SRC_GYRO, 2'd2, imu_att_pkg::SRC_DEG,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_G, 2'd2);
          4'd3: prog = imu_att_pkg::mac(imu_att_pkg::SRC_ACC, 2'd0, imu_att_pkg::SRC_ACC,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd4: prog = imu_att_pkg::mac(imu_att_pkg::SRC_ACC, 2'd1, imu_att_pkg::SRC_ACC,
                       2'd1, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_NONE, 2'd0);
          4'd5: prog = imu_att_pkg::mac(imu_att_pkg::SRC_ACC, 2'd2, imu_att_pkg::SRC_ACC,
                       2'd2, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_S, 2'd0);
          4'd6: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd1, imu_att_pkg::SRC_Q,
                       2'd3, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd7: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_Q,
                       2'd2, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_V, 2'd0);
          4'd8: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_Q,
                       2'd1, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd9: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd2, imu_att_pkg::SRC_Q,
                       2'd3, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_V, 2'd1);
          4'd10: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_Q,
                        2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd11: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd1, imu_att_pkg::SRC_Q,
                        2'd1, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_NONE, 2'd0);
          4'd12: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd2, imu_att_pkg::SRC_Q,
                        2'd2, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_NONE, 2'd0);
          4'd13: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd3, imu_att_pkg::SRC_Q,
                        2'd3, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_V, 2'd2);
          default: prog = '0;
        endcase
      end
      ST_ERR: begin
        len = ERR_LEN;
        unique case (cnt)
          4'd0: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd1, imu_att_pkg::SRC_V,
                       2'd2, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd1: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd2, imu_att_pkg::SRC_V,
                       2'd1, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_E, 2'd0);
          4'd2: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd2, imu_att_pkg::SRC_V,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd3: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd0, imu_att_pkg::SRC_V,
                       2'd2, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_E, 2'd1);
          4'd4: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd0, imu_att_pkg::SRC_V,
                       2'd1, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd5: prog = imu_att_pkg::mac(imu_att_pkg::SRC_AN, 2'd1, imu_att_pkg::SRC_V,
                       2'd0, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_E, 2'd2);
          default: prog = '0;
        endcase
      end
      ST_GAIN: begin
        len = GAIN_LEN;
        if (cnt < GAIN_LEN) begin
          prog = imu_att_pkg::mac(imu_att_pkg::SRC_GAIN, 2'd0, imu_att_pkg::SRC_E,
                 cnt[1:0], imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_GADD, cnt[1:0]);
        end
      end
      ST_DERIV: begin
        len = DERIV_LEN;
        unique case (cnt)
          4'd0: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd1, imu_att_pkg::SRC_G,
                       2'd0, imu_att_pkg::ACC_LOADN, imu_att_pkg::DST_NONE, 2'd0);
          4'd1: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd2, imu_att_pkg::SRC_G,
                       2'd1, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_NONE, 2'd0);
          4'd2: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd3, imu_att_pkg::SRC_G,
                       2'd2, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_DD, 2'd0);
          4'd3: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_G,
                       2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd4: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd2, imu_att_pkg::SRC_G,
                       2'd2, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_NONE, 2'd0);
          4'd5: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd3, imu_att_pkg::SRC_G,
                       2'd1, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_DD, 2'd1);
          4'd6: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_G,
                       2'd1, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd7: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd1, imu_att_pkg::SRC_G,
                       2'd2, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_NONE, 2'd0);
          4'd8: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd3, imu_att_pkg::SRC_G,
                       2'd0, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_DD, 2'd2);
          4'd9: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd0, imu_att_pkg::SRC_G,
                       2'd2, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NONE, 2'd0);
          4'd10: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd1, imu_att_pkg::SRC_G,
                        2'd1, imu_att_pkg::ACC_ADD, imu_att_pkg::DST_NONE, 2'd0);
          4'd11: prog = imu_att_pkg::mac(imu_att_pkg::SRC_Q, 2'd2, imu_att_pkg::SRC_G,
                        2'd0, imu_att_pkg::ACC_SUB, imu_att_pkg::DST_DD, 2'd3);
          default: prog = '0;
        endcase
      end
      ST_STEP: begin
        len = STEP_LEN;
        if (cnt < STEP_LEN) begin
          prog = imu_att_pkg::mac(imu_att_pkg::SRC_DD, cnt[1:0], imu_att_pkg::SRC_DT,
                 2'd0, imu_att_pkg::ACC_LOAD, imu_att_pkg::DST_NQ, cnt[1:0]);
        end
      end
      ST_QSUM: begin
        len = QSUM_LEN;
        if (cnt < QSUM_LEN) begin
          prog = imu_att_pkg::mac(imu_att_pkg::SRC_M, cnt[1:0], imu_att_pkg::SRC_M,
                 cnt[1:0], (cnt == 4'd0) ? imu_att_pkg::ACC_LOAD : imu_att_pkg::ACC_ADD,
                 (cnt == QSUM_LEN - 4'd1) ? imu_att_pkg::DST_SUM : imu_att_pkg::DST_NONE,
                 2'd0);
        end
      end
      default: begin
        prog = '0;
        len = 4'd0;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // Sequence the phases of one update
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    pend_next = pend;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = imu_att_pkg::DP_LOAD;
          state_next = ST_PRE;
          cnt_next = 4'd0;
        end
      end
      ST_PRE, ST_ERR, ST_GAIN, ST_DERIV, ST_STEP, ST_QSUM: begin
        if (cnt < len) cmd = prog;
        if (cnt == len + 4'd1) begin
          cnt_next = 4'd0;
          unique case (state)
            ST_PRE:   state_next = stat.s_zero ? ST_GAIN : ST_ANORM;
            ST_ERR:   state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_DERIV;
            ST_DERIV: state_next = ST_STEP;
            ST_STEP:  state_next = ST_QMAG;
            default:  state_next = ST_QSQRT;
          endcase
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_ANORM: begin
        if (stat.s_norm) state_next = ST_ASQRT;
        else cmd.op = imu_att_pkg::DP_ANORM;
      end
      ST_ASQRT, ST_QSQRT: begin
        if (!pend) begin
          cmd.op = (state == ST_ASQRT) ? imu_att_pkg::DP_ASQRT : imu_att_pkg::DP_QSQRT;
          pend_next = 1'b1;
        end else if (stat.sqrt_done) begin
          pend_next = 1'b0;
          cnt_next = 4'd0;
          state_next = (state == ST_ASQRT) ? ST_ADIV : ST_QDIV;
        end
      end
      ST_ADIV, ST_QDIV: begin
        if (!pend) begin
          cmd.op = (state == ST_ADIV) ? imu_att_pkg::DP_ADIV : imu_att_pkg::DP_QDIV;
          cmd.a_idx = cnt[1:0];
          pend_next = 1'b1;
        end else if (stat.div_done) begin
          pend_next = 1'b0;
          if (state == ST_ADIV && cnt == 4'd2) begin
            cnt_next = 4'd0;
            state_next = ST_ERR;
          end else if (state == ST_QDIV && cnt == 4'd3) begin
            cnt_next = 4'd0;
            state_next = ST_OUT;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      ST_QMAG: begin
        cmd.op = imu_att_pkg::DP_QMAG;
        state_next = ST_QNORM;
      end
      ST_QNORM: begin
        priority if (stat.m_zero) state_next = ST_OUT;
        else if (stat.m_big) cmd.op = imu_att_pkg::DP_QRSH;
        else if (stat.m_small) cmd.op = imu_att_pkg::DP_QLSH;
        else begin
          cnt_next = 4'd0;
          state_next = ST_QSUM;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op = imu_att_pkg::DP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= 4'd0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pend <= pend_next;
    end
  end

endmodule
